FILE: src/pti_pkg.sv
`default_nettype none

package pti_pkg;

	localparam int DATA_W     = 32;
	localparam int CNT_W      = 16;
	localparam int IDX_W      = 3;
	localparam int GUARD_BITS = 16;
	localparam int DIV_W      = DATA_W + GUARD_BITS;
	localparam int ACC_W      = DIV_W + 1;
	localparam int SUM_W      = 50;
	localparam int LIMB_W     = 32;
	localparam int PROD_W     = 96;

	localparam logic [IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEF0  = 3'd1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} pti_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} pti_div_rsp_t;

endpackage

`default_nettype wire

FILE: src/pti_if.sv
`default_nettype none

interface pti_req_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       lower_bound;
	logic signed [31:0]       upper_bound;
	logic        [15:0]       subintervals;

	modport source (output valid, output lower_bound, output upper_bound,
		output subintervals, input ready);
	modport sink (input valid, input lower_bound, input upper_bound,
		input subintervals, output ready);
endinterface

interface pti_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] integral;
	logic               overflow;
	logic               bad_count;

	modport source (output valid, output integral, output overflow,
		output bad_count, input ready);
	modport sink (input valid, input integral, input overflow,
		input bad_count, output ready);
endinterface

`default_nettype wire

FILE: src/pti_div.sv
`default_nettype none

module pti_div import pti_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  pti_div_req_t req,
	output pti_div_rsp_t rsp
);

	localparam int CB = $clog2(DIV_W + 1);

	logic [CB-1:0]    cnt_q;
	logic             done_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W:0]   shifted;
	logic [CNT_W:0]   diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		ge      = shifted >= {1'b0, dsr_q};
		diff    = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CB'(1)) && !req.start;
			if (req.start) begin
				cnt_q <= CB'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: src/polynomial_trapezoid_integrator_unit.sv
// A zero subinterval count (m = 0) goes straight to the result; otherwise
//   each of the m + 1 points takes d Horner steps, d the effective degree.
// The serial divider sets up the step; the shared multiplier then serves
//   each Horner step and forms four partial products for the final scale.
// Throughput: one transaction at a time, ready only while idle.
// Reset (arst_n, async, active low) clears degree, coefficients and control.
`default_nettype none

module polynomial_trapezoid_integrator_unit import pti_pkg::*; #(
	parameter int MAX_DEGREE = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [DATA_W-1:0] cfg_wdata,
	pti_req_if.sink           req,
	pti_rsp_if.source         rsp
);

	localparam int NUM_COEF = MAX_DEGREE + 1;
	localparam int KW       = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
	localparam int SH       = FRAC_BITS + GUARD_BITS + 1;
	localparam int HW       = 2 * (DATA_W + 1) + 1;
	localparam int RW       = PROD_W + 1;

	localparam logic signed [HW-1:0] HMAX = HW'(64'sd2147483647);
	localparam logic signed [HW-1:0] HMIN = HW'(-64'sd2147483648);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_DIV  = 10'b0000000010,
		ST_PT   = 10'b0000000100,
		ST_HMUL = 10'b0000001000,
		ST_HADD = 10'b0000010000,
		ST_SUM  = 10'b0000100000,
		ST_FMUL = 10'b0001000000,
		ST_FADD = 10'b0010000000,
		ST_RND  = 10'b0100000000,
		ST_FIN  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	logic [IDX_W-1:0]         poly_degree_q;
	logic signed [DATA_W-1:0] coef_q [NUM_COEF];

	logic signed [DATA_W-1:0] a_q;
	logic [CNT_W-1:0]         m_q;
	logic                     dneg_q;
	logic signed [ACC_W-1:0]  hg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]         i_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] y_q;
	logic [KW-1:0]            k_q;
	logic signed [SUM_W-1:0]  s_q;
	logic                     ovf_q;
	logic [1:0]               fi_q;
	logic [PROD_W-1:0]        prod_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     rovf_q;
	logic                     rbad_q;
	logic signed [HW-2:0]     p_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_integral_q;
	logic                     out_overflow_q;
	logic                     out_bad_q;

	logic                     accept;
	logic                     out_load;
	logic [KW-1:0]            deg;
	logic [KW-1:0]            k_m1;
	logic signed [DATA_W:0]   span;
	logic [DATA_W:0]          span_mag;
	pti_div_req_t             div_req;
	pti_div_rsp_t             div_rsp;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [DATA_W:0]   x_sum;
	logic signed [DATA_W:0]   mul_a;
	logic signed [DATA_W:0]   mul_b;
	logic signed [HW-1:0]     hsum;
	logic signed [DATA_W-1:0] y_new;
	logic                     h_sat;
	logic                     last_pt;
	logic signed [SUM_W-1:0]  fterm;
	logic [SUM_W-1:0]         s_mag;
	logic [ACC_W-1:0]         h_mag;
	logic [2*LIMB_W-1:0]      ma;
	logic [2*LIMB_W-1:0]      mb;
	logic [PROD_W-1:0]        part;
	logic                     neg;
	logic [RW-1:0]            rnd;
	logic [RW-1:0]            mag;
	logic                     r_sat;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	assign deg  = (poly_degree_q > IDX_W'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(poly_degree_q);
	assign k_m1 = k_q - 1'b1;

	always_comb begin
		span     = (DATA_W+1)'(req.upper_bound) - (DATA_W+1)'(req.lower_bound);
		span_mag = span[DATA_W] ? -span : span;
		div_req.start    = accept && (req.subintervals != '0);
		div_req.dividend = {span_mag[DATA_W-1:0], GUARD_BITS'(0)};
		div_req.divisor  = req.subintervals;
	end

	pti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		acc_sh = acc_q >>> GUARD_BITS;
		x_sum  = (DATA_W+1)'(a_q) + (DATA_W+1)'(acc_sh);
	end

	always_comb begin
		s_mag = s_q[SUM_W-1] ? -s_q : s_q;
		h_mag = hg_q[ACC_W-1] ? -hg_q : hg_q;
		ma    = (2*LIMB_W)'(s_mag);
		mb    = (2*LIMB_W)'(h_mag);
		if (state_q == ST_FMUL) begin
			mul_a = {1'b0, fi_q[0] ? ma[2*LIMB_W-1:LIMB_W] : ma[LIMB_W-1:0]};
			mul_b = {1'b0, fi_q[1] ? mb[2*LIMB_W-1:LIMB_W] : mb[LIMB_W-1:0]};
		end else begin
			mul_a = (DATA_W+1)'(y_q);
			mul_b = (DATA_W+1)'(x_q);
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	always_comb begin
		hsum  = (HW'(p_q) >>> FRAC_BITS) + HW'(coef_q[k_m1]);
		h_sat = (hsum > HMAX) || (hsum < HMIN);
		if (hsum > HMAX) begin
			y_new = 32'sh7fffffff;
		end else if (hsum < HMIN) begin
			y_new = 32'sh80000000;
		end else begin
			y_new = hsum[DATA_W-1:0];
		end
	end

	always_comb begin
		last_pt = (i_q == m_q);
		fterm   = ((i_q == '0) || last_pt) ? SUM_W'(y_q) : (SUM_W'(y_q) <<< 1);
	end

	always_comb begin
		unique case (fi_q)
			2'd0:    part = PROD_W'(p_q[2*LIMB_W-1:0]);
			2'd3:    part = PROD_W'(p_q[2*LIMB_W-1:0]) << (2 * LIMB_W);
			default: part = PROD_W'(p_q[2*LIMB_W-1:0]) << LIMB_W;
		endcase
	end

	always_comb begin
		neg   = s_q[SUM_W-1] ^ hg_q[ACC_W-1];
		rnd   = RW'(prod_q) + (RW'(1) << (SH - 1));
		mag   = rnd >> SH;
		r_sat = (mag > RW'(64'h80000000)) || (!neg && (mag > RW'(64'h7fffffff)));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req.subintervals == '0) ? ST_FIN : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_PT;
				end
			end
			ST_PT:   state_d = (deg == '0) ? ST_SUM : ST_HMUL;
			ST_HMUL: state_d = ST_HADD;
			ST_HADD: state_d = (k_m1 == '0) ? ST_SUM : ST_HMUL;
			ST_SUM:  state_d = last_pt ? ST_FMUL : ST_PT;
			ST_FMUL: state_d = ST_FADD;
			ST_FADD: state_d = (fi_q == 2'd3) ? ST_RND : ST_FMUL;
			ST_RND:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			poly_degree_q <= '0;
			for (int k = 0; k < NUM_COEF; k++) begin
				coef_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				if (cfg_idx == REG_DEGREE) begin
					poly_degree_q <= cfg_wdata[IDX_W-1:0];
				end
				for (int k = 0; k < NUM_COEF; k++) begin
					if (cfg_idx == REG_COEF0 + IDX_W'(k)) begin
						coef_q[k] <= cfg_wdata;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q    <= req.lower_bound;
					m_q    <= req.subintervals;
					dneg_q <= span[DATA_W];
					res_q  <= '0;
					rovf_q <= 1'b0;
					rbad_q <= (req.subintervals == '0);
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					hg_q  <= dneg_q ? -ACC_W'(div_rsp.quotient) : ACC_W'(div_rsp.quotient);
					acc_q <= '0;
					i_q   <= '0;
					s_q   <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_PT: begin
				x_q <= x_sum[DATA_W-1:0];
				y_q <= coef_q[deg];
				k_q <= deg;
			end
			ST_HMUL: begin
			end
			ST_HADD: begin
				y_q   <= y_new;
				k_q   <= k_m1;
				ovf_q <= ovf_q | h_sat;
			end
			ST_SUM: begin
				s_q    <= s_q + fterm;
				acc_q  <= acc_q + hg_q;
				i_q    <= i_q + 1'b1;
				fi_q   <= '0;
				prod_q <= '0;
			end
			ST_FMUL: begin
			end
			ST_FADD: begin
				prod_q <= prod_q + part;
				fi_q   <= fi_q + 1'b1;
			end
			ST_RND: begin
				rbad_q <= 1'b0;
				rovf_q <= ovf_q | r_sat;
				if (r_sat) begin
					res_q <= neg ? 32'sh80000000 : 32'sh7fffffff;
				end else begin
					res_q <= neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
				end
			end
			ST_FIN: begin
				if (out_load) begin
					out_integral_q <= res_q;
					out_overflow_q <= rovf_q;
					out_bad_q      <= rbad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.integral  = out_integral_q;
	assign rsp.overflow  = out_overflow_q;
	assign rsp.bad_count = out_bad_q;

endmodule

`default_nettype wire

FILE: src/pti_checker.sv
`default_nettype none

module pti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_integral,
	input logic        rsp_overflow,
	input logic        rsp_bad_count
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready stayed high after a request transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_integral)
			&& $stable(rsp_overflow) && $stable(rsp_bad_count)))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_bad_count) |-> (rsp_integral == 32'd0 && !rsp_overflow))
		else $error("zero-count result not cleared");

	a_no_rsp_out_of_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result valid out of reset");

endmodule

bind polynomial_trapezoid_integrator_unit pti_checker u_pti_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_integral  (rsp.integral),
	.rsp_overflow  (rsp.overflow),
	.rsp_bad_count (rsp.bad_count)
);

`default_nettype wire
